@@ hdl/level_set_boundary_clean_unit_defines.svh @@
// Assertion macros shared by the level-set boundary clean checker.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef LEVEL_SET_BOUNDARY_CLEAN_UNIT_DEFINES_SVH
`define LEVEL_SET_BOUNDARY_CLEAN_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LSBC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsbc_checker: implication check failed");

// Antecedent implies consequent in the following cycle.
`define LSBC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsbc_checker: next-cycle check failed");

`endif

@@ hdl/lsbc_pkg.sv @@
// Types, codes and helper functions for the level-set boundary clean unit.
// No dependencies; used by the top level and by its checker.
package lsbc_pkg;

  localparam int TDATA_W      = 8;
  localparam int VAL_W        = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;

  typedef logic signed [VAL_W-1:0] level_t;
  typedef logic [2*VAL_W-1:0]      pair_t;

  typedef struct packed {
    logic   last;
    level_t value;
  } result_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam level_t LEVEL_POS1 = 3'sd1;
  localparam level_t LEVEL_NEG1 = -3'sd1;
  localparam level_t LEVEL_POS3 = 3'sd3;
  localparam level_t LEVEL_NEG3 = -3'sd3;

  function automatic logic is_pos(level_t v);
    return !v[VAL_W-1] && (v != '0);
  endfunction

  function automatic logic is_neg(level_t v);
    return v[VAL_W-1];
  endfunction

  // A store word holds the same column of an even row (low half) and an odd row.
  function automatic level_t get_half(pair_t p, logic odd);
    return odd ? level_t'(p[2*VAL_W-1:VAL_W]) : level_t'(p[VAL_W-1:0]);
  endfunction

endpackage

@@ hdl/lsbc_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no dependencies.
module lsbc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/level_set_boundary_clean_unit.sv @@
// Level-set boundary clean: one item per cycle while in_tready is high; each result passes
// through stage 1 and the output queue. The column store does one read and one write per cycle.
// Reset is synchronous, active low, clears counters, pipeline and queue; store is not cleared.
// Depends on lsbc_pkg and lsbc_ram.
module level_set_boundary_clean_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lsbc_pkg::TDATA_W-1:0]     in_tdata,   // [2:0] level_value
  input  logic                             in_tuser,   // [0] opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lsbc_pkg::TDATA_W-1:0]     out_tdata,  // [2:0] cleaned_value
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lsbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lsbc_pkg::*;

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int RW         = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST      = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int H_RST      = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
  localparam int FIFO_DEPTH = 4;
  localparam int FAW        = $clog2(FIFO_DEPTH);

  function automatic logic [WW-1:0] clamp_w(logic [WIDTH_REG_W-1:0] v);
    if (v == '0) return WW'(1);
    else if (int'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
    else return WW'(v);
  endfunction

  function automatic logic [RW-1:0] clamp_h(logic [HEIGHT_REG_W-1:0] v);
    if (v == '0) return RW'(1);
    else if (int'(v) > MAX_HEIGHT) return RW'(MAX_HEIGHT);
    else return RW'(v);
  endfunction

  logic [WW-1:0] w_eff_r;
  logic [RW-1:0] h_eff_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic          cfg_fire, in_fire, pix_in, row_full, act, col_last;
  logic [WW-1:0] col_inc;
  logic [CW-1:0] rd_addr;

  logic          s1_valid_r, s1_pix_r, s1_emit_r, s1_above_r, s1_left_r;
  logic          s1_right_r, s1_half_r, s1_last_r, s1_fwd_hit_r;
  logic [CW-1:0] s1_col_r, s1_rd_addr_r;
  level_t        s1_val_r;
  pair_t         s1_fwd_data_r;

  pair_t         cur_r, ram_rdata, ahead, wr_data;
  level_t        left_r, above_v, center_v, right_v, res_v;
  logic          wr_en, all_pos, all_neg;
  logic [CW-1:0] wr_addr;

  result_t        fifo_r [FIFO_DEPTH];
  logic [FAW-1:0] fifo_wp_r, fifo_rp_r;
  logic [FAW:0]   fifo_cnt_r;
  logic           push, pop;
  result_t        head;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign pix_in    = (in_tuser == OP_PIXEL);
  assign row_full  = (row_r == h_eff_r);
  assign act       = in_fire && (pix_in ? !row_full : row_full);
  assign col_inc   = WW'(col_r) + WW'(1);
  assign col_last  = (col_inc == w_eff_r);
  assign rd_addr   = col_last ? '0 : col_inc[CW-1:0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_fire) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (act) begin
      if (!col_last) begin
        col_nxt = col_inc[CW-1:0];
      end else begin
        col_nxt = '0;
        row_nxt = pix_in ? row_r + RW'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= WW'(W_RST);
      h_eff_r <= RW'(H_RST);
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_WIDTH: begin
          w_eff_r <= clamp_w(cfg_data[WIDTH_REG_W-1:0]);
        end
        REG_HEIGHT: begin
          h_eff_r <= clamp_h(cfg_data[HEIGHT_REG_W-1:0]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= act;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      s1_pix_r      <= pix_in;
      s1_col_r      <= col_r;
      s1_val_r      <= level_t'(in_tdata[VAL_W-1:0]);
      s1_emit_r     <= (row_r != '0);
      s1_above_r    <= (row_r[RW-1:1] != '0);
      s1_left_r     <= (col_r != '0);
      s1_right_r    <= !col_last;
      s1_half_r     <= row_r[0];
      s1_last_r     <= !pix_in && col_last;
      s1_rd_addr_r  <= rd_addr;
      s1_fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
      s1_fwd_data_r <= wr_data;
    end
  end

  lsbc_ram #(
    .WIDTH (2 * VAL_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (act),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // The word read for the next column is patched with a write to the same column.
  assign ahead    = s1_fwd_hit_r ? s1_fwd_data_r : ram_rdata;
  assign above_v  = get_half(cur_r, s1_half_r);
  assign center_v = get_half(cur_r, !s1_half_r);
  assign right_v  = get_half(ahead, !s1_half_r);
  assign wr_en    = s1_valid_r && s1_pix_r;
  assign wr_addr  = s1_col_r;
  assign wr_data  = s1_half_r ? {s1_val_r, cur_r[VAL_W-1:0]}
                              : {cur_r[2*VAL_W-1:VAL_W], s1_val_r};

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      cur_r  <= (wr_en && (wr_addr == s1_rd_addr_r)) ? wr_data : ahead;
      left_r <= center_v;
    end
  end

  always_comb begin
    all_pos = (!s1_above_r || is_pos(above_v)) && (!s1_left_r || is_pos(left_r)) &&
              (!s1_right_r || is_pos(right_v)) && (!s1_pix_r || is_pos(s1_val_r));
    all_neg = (!s1_above_r || is_neg(above_v)) && (!s1_left_r || is_neg(left_r)) &&
              (!s1_right_r || is_neg(right_v)) && (!s1_pix_r || is_neg(s1_val_r));
    res_v = center_v;
    if (center_v == LEVEL_POS1 && all_pos) begin
      res_v = LEVEL_POS3;
    end else if (center_v == LEVEL_NEG1 && all_neg) begin
      res_v = LEVEL_NEG3;
    end
  end

  assign push = s1_valid_r && s1_emit_r;
  assign pop  = out_tvalid && out_tready;
  assign head = fifo_r[fifo_rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[fifo_wp_r] <= '{last: s1_last_r, value: res_v};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wp_r  <= '0;
      fifo_rp_r  <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        fifo_wp_r <= fifo_wp_r + FAW'(1);
      end
      if (pop) begin
        fifo_rp_r <= fifo_rp_r + FAW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + (FAW+1)'(push) - (FAW+1)'(pop);
    end
  end

  assign in_tready  = (int'(fifo_cnt_r) + int'(push)) < FIFO_DEPTH;
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = {{(TDATA_W-VAL_W){1'b0}}, head.value};
  assign out_tlast  = head.last;

endmodule

@@ hdl/lsbc_checker.sv @@
// Port-level checker for the level-set boundary clean unit, bound to the top level.
// Depends on lsbc_pkg and the assertion macros in the defines header.
`include "level_set_boundary_clean_unit_defines.svh"

module lsbc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [lsbc_pkg::TDATA_W-1:0]     in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lsbc_pkg::TDATA_W-1:0]     out_tdata,
  input logic                             out_tlast,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [lsbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [lsbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lsbc_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_tdata, in_tuser, cfg_valid, cfg_ready, cfg_index, cfg_data};

  `LSBC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `LSBC_ASSERT_IMPL(a_out_pad_zero, out_tvalid, out_tdata[TDATA_W-1:VAL_W] == '0)
  `LSBC_ASSERT_IMPL(a_stall_needs_backlog, !in_tready, out_tvalid)
  `LSBC_ASSERT_IMPL(a_word_has_cause, $rose(out_tvalid), $past(in_tvalid && in_tready, 2))

endmodule

bind level_set_boundary_clean_unit lsbc_checker u_lsbc_checker (.*);
